/* hdl/tgsa_pkg.sv */
// package: constants, types and helpers of the gather/scatter address generator
`timescale 1ns / 1ps
package tgsa_pkg;

  localparam int MAX_RANK    = 8;
  localparam int ADDR_BITS   = 32;
  localparam int EXTENT_BITS = 16;
  localparam int QBITS       = 4;
  localparam int DIV_STEPS   = ADDR_BITS / QBITS;
  localparam int NST         = MAX_RANK * DIV_STEPS + 2;
  localparam int LATENCY     = NST + 1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_AXIS     = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  localparam logic [2:0] REG_RANK    = 3'd0;
  localparam logic [2:0] REG_AXIS    = 3'd1;
  localparam logic [2:0] REG_DEXT_LO = 3'd2;
  localparam logic [2:0] REG_DEXT_HI = 3'd3;
  localparam logic [2:0] REG_IEXT_LO = 3'd4;
  localparam logic [2:0] REG_IEXT_HI = 3'd5;

  localparam logic [63:0] EXT_RESET = 64'h0001_0001_0001_0001;

  typedef struct packed {
    logic                 vld;
    logic                 bad_ax;
    logic                 bad;
    logic [2:0]           ax;
    logic [16:0]          ival;
    logic [ADDR_BITS-1:0] rem;
    logic [ADDR_BITS-1:0] quot;
    logic [ADDR_BITS-1:0] prod;
    logic [ADDR_BITS-1:0] sum;
  } stage_t;

  function automatic logic [EXTENT_BITS-1:0] ext_of(input logic [63:0] lo,
                                                    input logic [63:0] hi,
                                                    input logic [2:0]  d);
    logic [63:0] word;
    logic [15:0] f;
    word = d[2] ? hi : lo;
    unique case (d[1:0])
      2'd0: f = word[63:48];
      2'd1: f = word[47:32];
      2'd2: f = word[31:16];
      default: f = word[15:0];
    endcase
    return f[EXTENT_BITS-1:0];
  endfunction

endpackage

/* hdl/tensor_gather_scatter_address_top.sv */
// top level: pipelined gather/scatter element offset generator
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_flat_position, in_index_value        | start && !busy
//  result  | out_element_offset, out_status          | out_strobe, one cycle
//  config  | cfg_index, cfg_data                     | cfg_valid && cfg_ready
//
// one beat enters per cycle while busy is low; results leave in the order their beats entered
// depth is set by the per-dimension divider: 8 stages of 4 quotient bits per dim
// a config write waits for an empty pipeline with start low
// it then rebuilds the stride tables, busy through the INIT and RUN states
// synchronous active-low reset; results cannot be stalled
`timescale 1ns / 1ps
module tensor_gather_scatter_address_top
  import tgsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_flat_position,
  input  logic signed [16:0]   in_index_value,
  output logic                 out_strobe,
  output logic [31:0]          out_element_offset,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [1:0] {IDLE, INIT, RUN} seq_state_t;

  seq_state_t            state_r;
  logic [3:0]            rank_r;
  logic [3:0]            axis_r;
  logic [63:0]           dext_lo_r, dext_hi_r, iext_lo_r, iext_hi_r;
  logic [ADDR_BITS-1:0]  dstr_r [MAX_RANK];
  logic [ADDR_BITS-1:0]  istr_r [MAX_RANK];
  logic [ADDR_BITS-1:0]  ds_r, is_r;
  logic [3:0]            k_r;
  logic [2:0]            kd;
  logic [3:0]            erank;
  logic [EXTENT_BITS-1:0] dext [MAX_RANK];
  logic [EXTENT_BITS-1:0] iext [MAX_RANK];
  logic signed [4:0]     ax5;
  logic                  pipe_busy;
  stage_t                st_r   [NST+1];
  stage_t                st_nxt [1:NST];

  assign erank     = (rank_r > 4'(MAX_RANK)) ? 4'(MAX_RANK) : rank_r;
  assign busy      = (state_r != IDLE);
  assign cfg_ready = (state_r == IDLE) && !pipe_busy && !start;
  assign kd        = 3'(k_r - 4'd1);

  always_comb begin
    pipe_busy = 1'b0;
    for (int g = 0; g <= NST; g++) begin
      pipe_busy = pipe_busy | st_r[g].vld;
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      dext[d] = ext_of(dext_lo_r, dext_hi_r, 3'(d));
      iext[d] = ext_of(iext_lo_r, iext_hi_r, 3'(d));
    end
  end

  // stride rebuild sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      rank_r    <= 4'd1;
      axis_r    <= 4'd0;
      dext_lo_r <= EXT_RESET;
      dext_hi_r <= EXT_RESET;
      iext_lo_r <= EXT_RESET;
      iext_hi_r <= EXT_RESET;
      for (int d = 0; d < MAX_RANK; d++) begin
        dstr_r[d] <= ADDR_BITS'(1);
        istr_r[d] <= ADDR_BITS'(1);
      end
      ds_r <= ADDR_BITS'(1);
      is_r <= ADDR_BITS'(1);
      k_r  <= 4'd0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
              REG_RANK:    rank_r    <= cfg_data[3:0];
              REG_AXIS:    axis_r    <= cfg_data[3:0];
              REG_DEXT_LO: dext_lo_r <= cfg_data;
              REG_DEXT_HI: dext_hi_r <= cfg_data;
              REG_IEXT_LO: iext_lo_r <= cfg_data;
              REG_IEXT_HI: iext_hi_r <= cfg_data;
              default: ;
            endcase
            state_r <= INIT;
          end
        end
        INIT: begin
          for (int d = 0; d < MAX_RANK; d++) begin
            dstr_r[d] <= ADDR_BITS'(1);
            istr_r[d] <= ADDR_BITS'(1);
          end
          ds_r    <= ADDR_BITS'(1);
          is_r    <= ADDR_BITS'(1);
          k_r     <= erank;
          state_r <= RUN;
        end
        RUN: begin
          if (k_r == 4'd0) begin
            state_r <= IDLE;
          end else begin
            dstr_r[kd] <= ds_r;
            istr_r[kd] <= is_r;
            ds_r       <= ADDR_BITS'(ds_r * dext[kd]);
            is_r       <= ADDR_BITS'(is_r * iext[kd]);
            k_r        <= k_r - 4'd1;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // entry stage: axis normalization
  assign ax5 = signed'({axis_r[3], axis_r}) +
               (axis_r[3] ? signed'({1'b0, erank}) : 5'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else begin
      st_r[0].vld    <= start && !busy;
      st_r[0].bad_ax <= ax5[4] || (ax5 >= signed'({1'b0, erank}));
      st_r[0].bad    <= 1'b0;
      st_r[0].ax     <= ax5[2:0];
      st_r[0].ival   <= in_index_value;
      st_r[0].rem    <= in_flat_position;
      st_r[0].quot   <= '0;
      st_r[0].prod   <= '0;
      st_r[0].sum    <= '0;
    end
  end

  for (genvar g = 1; g <= NST; g++) begin : g_stage
    localparam int D   = (g - 1) / DIV_STEPS;
    localparam int S   = (g - 1) % DIV_STEPS;
    localparam int DI  = (D < MAX_RANK) ? D : 0;
    localparam int DP  = (D >= 1) ? D - 1 : 0;

    always_comb begin
      stage_t                 n;
      logic [EXTENT_BITS-1:0] ext;
      logic [17:0]            v;
      logic [15:0]            coord;
      logic                   badc;
      logic                   act;
      logic [2*ADDR_BITS-1:0] dv;
      n     = st_r[g-1];
      ext   = dext[DP];
      v     = '0;
      coord = '0;
      badc  = 1'b0;
      dv    = '0;
      // close previous dim: check, weight by data stride
      if (S == 0 && D >= 1) begin
        act = (4'(DP) < erank);
        if (n.ax == 3'(DP)) begin
          v     = {n.ival[16], n.ival} + (n.ival[16] ? {2'b00, ext} : 18'd0);
          badc  = v[17] || (v[16:0] >= {1'b0, ext});
          coord = v[15:0];
        end else begin
          badc  = (n.quot >= ADDR_BITS'(ext));
          coord = n.quot[15:0];
        end
        n.prod = act ? ADDR_BITS'(coord * dstr_r[DP]) : '0;
        n.bad  = n.bad | (act & badc);
        n.quot = '0;
      end
      if (S == 1 && D >= 1) begin
        n.sum = n.sum + n.prod;
      end
      // restoring divide, 4 quotient bits per stage
      act = (D < MAX_RANK) && (4'(DI) < erank) && (istr_r[DI] != '0);
      if (act) begin
        for (int j = 0; j < QBITS; j++) begin
          dv = {{ADDR_BITS{1'b0}}, istr_r[DI]} << (ADDR_BITS - 1 - S * QBITS - j);
          if ({{ADDR_BITS{1'b0}}, n.rem} >= dv) begin
            n.rem = n.rem - dv[ADDR_BITS-1:0];
            n.quot[ADDR_BITS-1-S*QBITS-j] = 1'b1;
          end
        end
      end
      st_nxt[g] = n;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].vld <= 1'b0;
      end else begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign out_strobe = st_r[NST].vld;
  assign out_status = st_r[NST].bad_ax ? ST_BAD_AXIS :
                      st_r[NST].bad    ? ST_OUT_OF_RANGE : ST_OK;
  assign out_element_offset = (out_status == ST_OK) ? st_r[NST].sum : '0;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("result beat missing");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("stride rebuild not started");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_OK || out_status == ST_BAD_AXIS ||
                    out_status == ST_OUT_OF_RANGE))
    else $error("bad status code");

endmodule

/* verif/tgsa_checker.sv */
// checker: predicts element offsets and status from accepted beats and compares results
`timescale 1ns / 1ps
module tgsa_checker
  import tgsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_flat_position,
  input  logic [16:0] in_index_value,
  input  logic        out_strobe,
  input  logic [31:0] out_element_offset,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0] offset;
    logic [1:0]  status;
  } offset_beat_t;

  offset_beat_t expected_offsets[$];

  logic [3:0]  rank_q;
  logic [3:0]  axis_q;
  logic [63:0] dext_lo, dext_hi, iext_lo, iext_hi;
  logic [31:0] data_stride[8];
  logic [31:0] index_stride[8];

  assign pending = expected_offsets.size();

  function automatic logic [31:0] extent(input logic [63:0] lo, input logic [63:0] hi,
                                         input int d);
    logic [63:0] word;
    word = (d < 4) ? lo : hi;
    return 32'((word >> (48 - 16 * (d % 4))) & 64'hFFFF);
  endfunction

  function automatic int live_rank();
    return (rank_q > 4'd8) ? 8 : int'(rank_q);
  endfunction

  task automatic rebuild_strides();
    logic [31:0] ds, is;
    int r;
    ds = 1;
    is = 1;
    r = live_rank();
    for (int k = 0; k < 8; k++) begin
      data_stride[k] = 1;
      index_stride[k] = 1;
    end
    for (int k = r; k > 0; k--) begin
      data_stride[k-1] = ds;
      index_stride[k-1] = is;
      ds = ds * extent(dext_lo, dext_hi, k - 1);
      is = is * extent(iext_lo, iext_hi, k - 1);
    end
  endtask

  function automatic offset_beat_t predict_offset(input logic [31:0] pos,
                                                  input logic [16:0] ival);
    offset_beat_t res;
    int r, ax, v;
    logic [31:0] rem, coord, istr, ext, sum;
    bit bad;
    r = live_rank();
    ax = int'($signed(axis_q));
    rem = pos;
    sum = 0;
    bad = 0;
    if (ax < 0) ax += r;
    if (ax < 0 || ax >= r) begin
      res.offset = 0;
      res.status = ST_BAD_AXIS;
      return res;
    end
    for (int d = 0; d < r; d++) begin
      istr = index_stride[d];
      ext = extent(dext_lo, dext_hi, d);
      coord = 0;
      if (istr != 0) begin
        coord = rem / istr;
        rem = rem % istr;
      end
      if (d == ax) begin
        v = int'($signed(ival));
        if (v < 0) v += int'(ext);
        if (v < 0 || v >= int'(ext)) begin
          bad = 1;
          coord = 0;
        end else begin
          coord = 32'(v);
        end
      end else if (coord >= ext) begin
        bad = 1;
      end
      sum = sum + coord * data_stride[d];
    end
    res.offset = bad ? 32'd0 : sum;
    res.status = bad ? ST_OUT_OF_RANGE : ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    offset_beat_t want;
    if (!rst_n) begin
      rank_q = 4'd1;
      axis_q = 4'd0;
      dext_lo = EXT_RESET;
      dext_hi = EXT_RESET;
      iext_lo = EXT_RESET;
      iext_hi = EXT_RESET;
      rebuild_strides();
      expected_offsets.delete();
    end else begin
      if (out_strobe) begin
        if (expected_offsets.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_offsets.pop_front();
          if (out_element_offset !== want.offset)
            report_mismatch($sformatf("offset got %h want %h", out_element_offset,
                                      want.offset));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANK:    rank_q = cfg_data[3:0];
          REG_AXIS:    axis_q = cfg_data[3:0];
          REG_DEXT_LO: dext_lo = cfg_data;
          REG_DEXT_HI: dext_hi = cfg_data;
          REG_IEXT_LO: iext_lo = cfg_data;
          REG_IEXT_HI: iext_hi = cfg_data;
          default: ;
        endcase
        rebuild_strides();
      end
      if (start && !busy)
        expected_offsets.push_back(predict_offset(in_flat_position, in_index_value));
    end
  end

endmodule

/* verif/tb.sv */
// testbench top: stimulus, configuration phases and verdict for the offset generator
`timescale 1ns / 1ps
module tb;
  import tgsa_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] in_flat_position = 0;
  logic [16:0] in_index_value = 0;
  logic        out_strobe;
  logic [31:0] out_element_offset;
  logic [1:0]  out_status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_RANK;
  logic [63:0] cfg_data = 0;
  int          fail_count;
  int          pending;

  int  dext[8];
  int  iext[8];
  int  cur_rank;
  int  cur_axis;
  bit  allow_idle;

  always #1 clk = ~clk;

  tensor_gather_scatter_address_top i_dut (
    .clk, .rst_n, .start, .busy,
    .in_flat_position,
    .in_index_value(signed'(in_index_value)),
    .out_strobe, .out_element_offset, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tgsa_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_flat_position, .in_index_value,
    .out_strobe, .out_element_offset, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  function automatic logic [63:0] pack_ext(input int a, input int b, input int c,
                                           input int d);
    return {a[15:0], b[15:0], c[15:0], d[15:0]};
  endfunction

  task automatic send_beat(input logic [31:0] pos, input logic [16:0] ival);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1;
    in_flat_position <= pos;
    in_index_value <= ival;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    if (allow_idle) repeat ($urandom_range(0, 8)) @(negedge clk);
  endtask

  task automatic apply_config(input int r, input int ax);
    drain();
    cur_rank = r;
    cur_axis = ax;
    write_reg(REG_DEXT_LO, pack_ext(dext[0], dext[1], dext[2], dext[3]));
    write_reg(REG_DEXT_HI, pack_ext(dext[4], dext[5], dext[6], dext[7]));
    write_reg(REG_IEXT_LO, pack_ext(iext[0], iext[1], iext[2], iext[3]));
    write_reg(REG_IEXT_HI, pack_ext(iext[4], iext[5], iext[6], iext[7]));
    write_reg(REG_AXIS, 64'(ax[3:0]));
    write_reg(REG_RANK, 64'(r[3:0]));
  endtask

  task automatic random_beat();
    longint prod;
    int r, ax, e, v;
    logic [31:0] pos;
    r = (cur_rank > 8) ? 8 : cur_rank;
    prod = 1;
    for (int d = 0; d < r; d++) prod = prod * iext[d];
    if (prod > 0 && prod < 64'h1_0000_0000 && $urandom_range(0, 9) < 8)
      pos = 32'($urandom_range(0, int'(prod - 1)));
    else
      pos = $urandom;
    ax = cur_axis;
    if (ax < 0) ax += r;
    e = (ax >= 0 && ax < 8) ? dext[ax] : 1;
    if ($urandom_range(0, 9) < 8) begin
      v = int'($urandom_range(0, 2 * e)) - e;
      send_beat(pos, 17'(v));
    end else begin
      send_beat(pos, 17'($urandom));
    end
  endtask

  task automatic random_config();
    int r, ax, sel;
    sel = $urandom_range(0, 9);
    r = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
    ax = (sel == 2) ? int'($urandom_range(0, 15)) - 8 :
         (r > 0 ? int'($urandom_range(0, ((r > 8) ? 8 : r) - 1)) : 0);
    if (sel == 3 && ax > 0) ax = ax - ((r > 8) ? 8 : r);
    for (int d = 0; d < 8; d++) begin
      case ($urandom_range(0, 11))
        0: dext[d] = $urandom_range(0, 65535);
        1: dext[d] = 0;
        default: dext[d] = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0: iext[d] = $urandom_range(0, 65535);
        1: iext[d] = 0;
        default: iext[d] = (dext[d] > 0 && dext[d] <= 8) ? $urandom_range(1, dext[d]) :
                           $urandom_range(1, 8);
      endcase
    end
    apply_config(r, ax);
  endtask

  initial begin
    #2000000;
    $display("tensor_gather_scatter_address_top: mismatch");
    $finish;
  end

  initial begin
    allow_idle = 1;
    cur_rank = 1;
    cur_axis = 0;
    for (int d = 0; d < 8; d++) begin
      dext[d] = 1;
      iext[d] = 1;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // reset setting
    send_beat(0, 17'd0);
    send_beat(0, -17'sd1);
    send_beat(1, 17'd1);
    send_beat(32'hFFFF_FFFF, 17'd65535);
    send_beat(0, -17'sd65535);

    dext = '{4, 5, 6, 1, 1, 1, 1, 1};
    iext = '{4, 3, 6, 1, 1, 1, 1, 1};
    apply_config(3, 1);
    send_beat(0, 17'd0);
    send_beat(71, 17'd4);
    send_beat(71, -17'sd5);
    send_beat(72, 17'd0);
    send_beat(10, 17'd5);
    send_beat(10, -17'sd6);
    send_beat(32'hFFFF_FFFF, 17'h1FFFF);

    apply_config(3, -8);
    send_beat(5, 17'd0);
    apply_config(3, 7);
    send_beat(5, 17'd0);
    apply_config(0, 0);
    send_beat(0, 17'd0);

    dext = '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535};
    iext = '{65535, 0, 65535, 65535, 65535, 65535, 65535, 65535};
    apply_config(15, -1);
    send_beat(32'hFFFF_FFFF, 17'hFFFF);
    send_beat(32'h1234_5678, -17'sd65535);
    dext[2] = 0;
    apply_config(8, 0);
    send_beat(3, 17'd7);

    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      allow_idle = (ph < 10) && (ph % 3 != 1);
      repeat (115) random_beat();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tensor_gather_scatter_address_top: match");
    end else begin
      $display("tensor_gather_scatter_address_top: mismatch");
    end
    $finish;
  end

endmodule
